// ===== hw/rtl/bdlp_pkg.sv =====
`default_nettype none
package bdlp_pkg;

	localparam int NUM_BUTTONS_DEF = 4;

	localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd800;

	localparam logic REG_DEBOUNCE   = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} bdlp_event_t;

	typedef struct packed {
		logic        is_down;
		logic [31:0] down_since;
		logic        long_done;
		logic        settling;
		logic [31:0] settle_since;
	} bdlp_entry_t;

	typedef struct packed {
		bdlp_event_t event_kind;
		logic        stable_pressed;
		logic        long_held;
		logic [31:0] held_ms;
	} bdlp_result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bdlp_state_ram.sv =====
`default_nettype none
module bdlp_state_ram
	import bdlp_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
	localparam int AddrW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [AddrW-1:0] rd_addr,
	output bdlp_entry_t           rd_data,
	input  wire logic             wr_en,
	input  wire logic [AddrW-1:0] wr_addr,
	input  wire bdlp_entry_t      wr_data
);

	bdlp_entry_t             mem_q [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]  vld_q;
	bdlp_entry_t             rd_data_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// entries never written read as the reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/bdlp_update.sv =====
`default_nettype none
module bdlp_update
	import bdlp_pkg::*;
(
	input  wire bdlp_entry_t  cur,
	input  wire logic         raw_pressed,
	input  wire logic [31:0]  now_ms,
	input  wire logic [15:0]  debounce_ms,
	input  wire logic [15:0]  long_lim_ms,
	output bdlp_entry_t       nxt,
	output bdlp_result_t      res
);

	logic [31:0] d_settle;
	logic [31:0] d_down;
	logic [31:0] held;
	logic        press_now;
	bdlp_event_t ev;

	assign d_settle = now_ms - cur.settle_since;
	assign d_down   = now_ms - cur.down_since;

	always_comb begin
		nxt       = cur;
		ev        = EV_NONE;
		press_now = 1'b0;
		if (raw_pressed != cur.is_down) begin
			if (!cur.settling) begin
				nxt.settling     = 1'b1;
				nxt.settle_since = now_ms;
			end else if (d_settle >= {16'd0, debounce_ms}) begin
				if (raw_pressed) begin
					nxt.is_down    = 1'b1;
					nxt.down_since = now_ms;
					nxt.long_done  = 1'b0;
					press_now      = 1'b1;
				end else begin
					if (!cur.long_done && (d_down < {16'd0, long_lim_ms})) begin
						ev = EV_SHORT;
					end
					nxt.is_down   = 1'b0;
					nxt.long_done = 1'b0;
				end
				nxt.settling = 1'b0;
			end
		end
		held = press_now ? 32'd0 : d_down;
		if (nxt.is_down && !nxt.long_done && (held >= {16'd0, long_lim_ms})) begin
			nxt.long_done = 1'b1;
			ev            = EV_LONG;
		end
		res.event_kind     = ev;
		res.stable_pressed = nxt.is_down;
		res.long_held      = nxt.is_down && nxt.long_done;
		res.held_ms        = nxt.is_down ? held : 32'd0;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/button_debounce_long_press_core.sv =====
`default_nettype none
// channel  | handshake                    | payload
// sample   | sample_valid / sample_stall  | button, raw_pressed, now_ms
// result   | result_valid / result_stall  | event_kind, stable_pressed, long_held, held_ms
// config   | cfg_we                       | cfg_idx, cfg_data
//
// One sample per cycle. State read at accept, updated in stage 1 and written
// back; a same-button sample right behind takes the written entry by bypass.
// Result is registered from stage 1, in an output register.
// Reset clears all state at once (per-entry valid bits); no clearing pass.
// A stalled result holds stage 1; the sample side stalls only then.
module button_debounce_long_press_core
	import bdlp_pkg::*;
#(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [15:0] cfg_data,
	input  wire logic        sample_valid,
	output logic             sample_stall,
	input  wire logic [1:0]  button,
	input  wire logic        raw_pressed,
	input  wire logic [31:0] now_ms,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       event_kind,
	output logic             stable_pressed,
	output logic             long_held,
	output logic [31:0]      held_ms
);

	localparam int AddrW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	logic [15:0]      deb_q;
	logic [15:0]      lp_q;

	logic             vld_s1;
	logic [AddrW-1:0] addr_s1;
	logic             raw_s1;
	logic [31:0]      now_s1;
	logic             in_range_s1;
	logic             fwd_s1;
	bdlp_entry_t      last_wr_q;

	bdlp_result_t     res_q;

	logic             accept;
	logic             adv_s1;
	logic             wr_en;
	logic             in_range;
	logic [AddrW-1:0] in_addr;
	bdlp_entry_t      rd_data;
	bdlp_entry_t      cur;
	bdlp_entry_t      nxt;
	bdlp_result_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q <= DEBOUNCE_RESET;
			lp_q  <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DEBOUNCE:   deb_q <= cfg_data;
				REG_LONG_PRESS: lp_q  <= cfg_data;
				default:        deb_q <= deb_q;
			endcase
		end
	end

	assign in_addr      = AddrW'(button);
	assign in_range     = 32'(button) < 32'(NUM_BUTTONS);
	assign adv_s1       = !result_valid || !result_stall;
	assign sample_stall = vld_s1 && !adv_s1;
	assign accept       = sample_valid && !sample_stall;
	assign wr_en        = vld_s1 && adv_s1 && in_range_s1;

	bdlp_state_ram #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_range),
		.rd_addr (in_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (nxt)
	);

	assign cur = fwd_s1 ? last_wr_q : rd_data;

	bdlp_update u_update (
		.cur           (cur),
		.raw_pressed   (raw_s1),
		.now_ms        (now_s1),
		.debounce_ms   (deb_q),
		.long_lim_ms   (lp_q),
		.nxt           (nxt),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (!sample_stall) begin
				vld_s1 <= accept;
			end
			if (adv_s1) begin
				result_valid <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= in_addr;
			raw_s1      <= raw_pressed;
			now_s1      <= now_ms;
			in_range_s1 <= in_range;
			fwd_s1      <= wr_en && (addr_s1 == in_addr);
		end
		if (wr_en) begin
			last_wr_q <= nxt;
		end
		if (vld_s1 && adv_s1) begin
			res_q <= in_range_s1 ? res : '0;
		end
	end

	assign event_kind     = res_q.event_kind;
	assign stable_pressed = res_q.stable_pressed;
	assign long_held      = res_q.long_held;
	assign held_ms        = res_q.held_ms;

endmodule
`default_nettype wire

// ===== verif/tb_button_debounce_long_press_core.sv =====
module tb_button_debounce_long_press_core;
	timeunit 1ns;
	timeprecision 1ps;

	import bdlp_pkg::*;

	localparam int CYCLE_LIMIT = 500_000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 140;
	localparam int MAX_REPORTS = 50;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_idx;
	logic [15:0] cfg_data;
	logic        sample_valid;
	logic        sample_stall;
	logic [1:0]  button;
	logic        raw_pressed;
	logic [31:0] now_ms;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  event_kind;
	logic        stable_pressed;
	logic        long_held;
	logic [31:0] held_ms;

	// predictor state, one entry per button
	logic        key_down     [NUM_BUTTONS_DEF];
	logic [31:0] key_since    [NUM_BUTTONS_DEF];
	logic        key_long     [NUM_BUTTONS_DEF];
	logic        key_settling [NUM_BUTTONS_DEF];
	logic [31:0] key_settle_t [NUM_BUTTONS_DEF];
	logic [15:0] model_debounce;
	logic [15:0] model_long_press;

	bdlp_result_t outcome_q[$];

	int err_count;
	int cycle_count;
	int hold_ask;
	int hold_left;
	int rx_busy;
	int rx_free;
	bit rx_calm;
	bit tx_calm;

	button_debounce_long_press_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.button         (button),
		.raw_pressed    (raw_pressed),
		.now_ms         (now_ms),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.event_kind     (event_kind),
		.stable_pressed (stable_pressed),
		.long_held      (long_held),
		.held_ms        (held_ms)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bdlp_result_t predict_press_outcome(input logic [1:0] b,
		input logic raw, input logic [31:0] t);
		bdlp_result_t r;
		bdlp_event_t  ev;
		logic [31:0]  since_settle;
		logic [31:0]  hold;
		r = '0;
		ev = EV_NONE;
		if (int'(b) >= NUM_BUTTONS_DEF)
			return r;
		if (raw != key_down[b]) begin
			since_settle = t - key_settle_t[b];
			if (!key_settling[b]) begin
				key_settling[b] = 1'b1;
				key_settle_t[b] = t;
			end else if (since_settle >= {16'd0, model_debounce}) begin
				if (raw) begin
					key_down[b]  = 1'b1;
					key_since[b] = t;
					key_long[b]  = 1'b0;
				end else begin
					hold = t - key_since[b];
					if (!key_long[b] && hold < {16'd0, model_long_press})
						ev = EV_SHORT;
					key_down[b] = 1'b0;
					key_long[b] = 1'b0;
				end
				key_settling[b] = 1'b0;
			end
		end
		hold = t - key_since[b];
		if (key_down[b] && !key_long[b] && hold >= {16'd0, model_long_press}) begin
			key_long[b] = 1'b1;
			ev = EV_LONG;
		end
		r.event_kind     = ev;
		r.stable_pressed = key_down[b];
		r.long_held      = key_down[b] & key_long[b];
		r.held_ms        = key_down[b] ? hold : 32'd0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (err_count < MAX_REPORTS)
			$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// scoreboard: results against predictions, predictions made at sample accept
	always @(posedge clk) begin
		bdlp_result_t want;
		if (result_valid === 1'b1 && result_stall === 1'b0) begin
			if (outcome_q.size() == 0) begin
				report_mismatch("result beat with nothing pending", held_ms, 32'd0);
			end else begin
				want = outcome_q.pop_front();
				if (event_kind !== want.event_kind)
					report_mismatch("event_kind", 32'(event_kind), 32'(want.event_kind));
				if (stable_pressed !== want.stable_pressed)
					report_mismatch("stable_pressed", 32'(stable_pressed),
						32'(want.stable_pressed));
				if (long_held !== want.long_held)
					report_mismatch("long_held", 32'(long_held), 32'(want.long_held));
				if (held_ms !== want.held_ms)
					report_mismatch("held_ms", held_ms, want.held_ms);
			end
		end
		if (cfg_we === 1'b1) begin
			if (cfg_idx == REG_DEBOUNCE)
				model_debounce = cfg_data;
			else
				model_long_press = cfg_data;
		end
		if (arst_n === 1'b1 && sample_valid === 1'b1 && sample_stall === 1'b0)
			outcome_q.push_back(predict_press_outcome(button, raw_pressed, now_ms));
	end

	// result side stall pattern, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_ask != 0) begin
			hold_left = hold_ask;
			hold_ask = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (rx_calm) begin
			result_stall <= 1'b0;
		end else if (rx_busy != 0) begin
			rx_busy--;
			result_stall <= 1'b1;
		end else if (rx_free != 0) begin
			rx_free--;
			result_stall <= 1'b0;
		end else begin
			rx_busy = pick_gap();
			rx_free = pick_gap();
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("button_debounce_long_press_core regression: fail");
			$finish;
		end
	end

	task automatic send_sample(input logic [1:0] b, input logic raw, input logic [31:0] t);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		button       <= b;
		raw_pressed  <= raw;
		now_ms       <= t;
		do
			@(posedge clk);
		while (sample_stall !== 1'b0);
	endtask

	task automatic wait_idle();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_times(input logic [15:0] db, input logic [15:0] lp);
		wait_idle();
		write_reg(REG_DEBOUNCE, db);
		write_reg(REG_LONG_PRESS, lp);
	endtask

	// reset values: long press, release after long, short press, bounce back, wrap
	task automatic test_reset_timing();
		send_sample(2'd0, 1'b1, 32'd100);
		send_sample(2'd0, 1'b1, 32'd149);
		send_sample(2'd0, 1'b1, 32'd150);
		send_sample(2'd0, 1'b1, 32'd949);
		send_sample(2'd0, 1'b1, 32'd950);
		send_sample(2'd0, 1'b0, 32'd1010);
		send_sample(2'd0, 1'b0, 32'd1060);
		send_sample(2'd3, 1'b1, 32'd2000);
		send_sample(2'd3, 1'b1, 32'd2050);
		send_sample(2'd3, 1'b0, 32'd2100);
		send_sample(2'd3, 1'b0, 32'd2150);
		send_sample(2'd1, 1'b1, 32'd3000);
		send_sample(2'd1, 1'b0, 32'd3030);
		send_sample(2'd1, 1'b1, 32'd3050);
		send_sample(2'd2, 1'b1, 32'hFFFF_FFF0);
		send_sample(2'd2, 1'b1, 32'h0000_0022);
		send_sample(2'd2, 1'b1, 32'hFFFF_FFFF);
	endtask

	// zero times: a confirmed press fires the long event at once
	task automatic test_zero_times();
		set_times(16'd0, 16'd0);
		send_sample(2'd3, 1'b1, 32'd5);
		send_sample(2'd3, 1'b1, 32'd5);
		send_sample(2'd3, 1'b0, 32'd6);
		send_sample(2'd3, 1'b0, 32'd6);
	endtask

	task automatic test_max_times();
		set_times(16'hFFFF, 16'hFFFF);
		send_sample(2'd0, 1'b1, 32'd0);
		send_sample(2'd0, 1'b1, 32'd65534);
		send_sample(2'd0, 1'b1, 32'd65535);
		send_sample(2'd0, 1'b1, 32'd131069);
		send_sample(2'd0, 1'b1, 32'd131070);
	endtask

	// random presses per button with bounce, plus raw noise, under several timings
	task automatic test_random_presses();
		longint      vt;
		longint      flip_at   [NUM_BUTTONS_DEF];
		longint      last_flip [NUM_BUTTONS_DEF];
		bit          level     [NUM_BUTTONS_DEF];
		logic [31:0] t0;
		logic [15:0] db;
		logic [15:0] lp;
		int unsigned step_max;
		int unsigned bw;
		int unsigned dur;
		logic [1:0]  b;
		logic        raw;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin db = DEBOUNCE_RESET; lp = LONG_PRESS_RESET; end
				1: begin db = 16'd0;          lp = 16'd0;            end
				2: begin db = 16'hFFFF;       lp = 16'hFFFF;         end
				3: begin db = 16'd1;          lp = 16'd2;            end
				default: begin
					db = 16'($urandom_range(0, 65535));
					lp = 16'($urandom_range(0, 65535));
				end
			endcase
			set_times(db, lp);
			rx_calm = (p == 1);
			tx_calm = (p == 1);
			t0 = (p == 3) ? 32'hFFFF_FF00 : $urandom();
			vt = 0;
			step_max = 32'(db) / 4 + 1;
			bw = 32'(db) / 2;
			for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
				level[i] = 1'b0;
				last_flip[i] = 0;
				flip_at[i] = longint'($urandom_range(0, 4 * step_max));
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 10) begin
					send_sample(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
						$urandom());
				end else begin
					vt += longint'($urandom_range(0, step_max));
					b = 2'($urandom_range(0, 3));
					if (vt >= flip_at[b]) begin
						level[b] = !level[b];
						last_flip[b] = vt;
						if (level[b])
							dur = $urandom_range(0, 1) ? $urandom_range(0, 32'(lp)) :
								$urandom_range(32'(lp), 2 * 32'(lp) + 32'(db) + 1);
						else
							dur = $urandom_range(32'(db), 3 * 32'(db) + 10);
						flip_at[b] = vt + longint'(dur);
					end
					raw = level[b];
					if (vt - last_flip[b] < longint'(bw))
						raw = 1'($urandom_range(0, 1));
					send_sample(b, raw, t0 + vt[31:0]);
				end
			end
		end
		rx_calm = 1'b0;
		tx_calm = 1'b0;
	endtask

	// result side held off while samples keep coming, so the input stalls
	task automatic test_backpressure();
		logic [31:0] t;
		set_times(16'd10, 16'd100);
		t = 32'd5000;
		tx_calm = 1'b1;
		hold_ask = 300;
		for (int n = 0; n < 40; n++) begin
			t += $urandom_range(0, 8);
			send_sample(2'(n % NUM_BUTTONS_DEF), $urandom_range(0, 3) != 0, t);
		end
		tx_calm = 1'b0;
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = REG_DEBOUNCE;
		cfg_data     = 16'd0;
		sample_valid = 1'b0;
		button       = 2'd0;
		raw_pressed  = 1'b0;
		now_ms       = 32'd0;
		result_stall = 1'b0;
		err_count    = 0;
		cycle_count  = 0;
		hold_ask     = 0;
		hold_left    = 0;
		rx_busy      = 0;
		rx_free      = 0;
		rx_calm      = 1'b0;
		tx_calm      = 1'b0;
		model_debounce   = DEBOUNCE_RESET;
		model_long_press = LONG_PRESS_RESET;
		for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
			key_down[i]     = 1'b0;
			key_since[i]    = 32'd0;
			key_long[i]     = 1'b0;
			key_settling[i] = 1'b0;
			key_settle_t[i] = 32'd0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_timing();
		test_zero_times();
		test_max_times();
		test_random_presses();
		test_backpressure();

		wait_idle();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("button_debounce_long_press_core regression: pass");
		else
			$display("button_debounce_long_press_core regression: fail");
		$finish;
	end

endmodule
